[rtl/mmce_pkg.sv]
// Package for the memory-to-memory instruction execute block.
// Holds word layout, opcode and status codes, and the execute unit structs.
// Depends on nothing.
package mmce_pkg;

  localparam int WORD_W = 64;
  localparam int UB_W = 11;
  localparam int OP_W = 5;
  localparam int OPC_W = 2;
  localparam int ST_W = 3;

  localparam int DATA_WORDS_DEF = 2048;
  localparam int INST_WORDS_DEF = 1024;
  localparam logic [UB_W-1:0] USER_BASE_RST = 11'd1000;

  localparam logic [1:0] W_PC = 2'd0;
  localparam logic [1:0] W_SP = 2'd1;
  localparam logic [1:0] W_RES = 2'd2;
  localparam logic [1:0] W_CNT = 2'd3;

  localparam logic [OP_W-1:0] OP_SET = 5'd0;
  localparam logic [OP_W-1:0] OP_CPY = 5'd1;
  localparam logic [OP_W-1:0] OP_CPYI = 5'd2;
  localparam logic [OP_W-1:0] OP_CPYI2 = 5'd3;
  localparam logic [OP_W-1:0] OP_ADD = 5'd4;
  localparam logic [OP_W-1:0] OP_ADDI = 5'd5;
  localparam logic [OP_W-1:0] OP_SUBI = 5'd6;
  localparam logic [OP_W-1:0] OP_JIF = 5'd7;
  localparam logic [OP_W-1:0] OP_PUSH = 5'd8;
  localparam logic [OP_W-1:0] OP_POP = 5'd9;
  localparam logic [OP_W-1:0] OP_CALL = 5'd10;
  localparam logic [OP_W-1:0] OP_RET = 5'd11;
  localparam logic [OP_W-1:0] OP_HLT = 5'd12;
  localparam logic [OP_W-1:0] OP_USER = 5'd13;
  localparam logic [OP_W-1:0] OP_PRN = 5'd14;
  localparam logic [OP_W-1:0] OP_SHLT = 5'd15;
  localparam logic [OP_W-1:0] OP_YIELD = 5'd16;
  localparam logic [OP_W-1:0] OP_EMPTY = 5'd17;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_VIOL = 3'd1;
  localparam logic [ST_W-1:0] ST_STACK = 3'd2;
  localparam logic [ST_W-1:0] ST_PC = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;
  localparam logic [ST_W-1:0] ST_LOAD = 3'd5;

  localparam logic [WORD_W-1:0] RES_SHLT = 64'd3;
  localparam logic [WORD_W-1:0] RES_YIELD = 64'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [OPC_W-1:0] opc;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] va;
    logic [WORD_W-1:0] vb;
    logic [WORD_W-1:0] vc;
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] sp;
    logic [WORD_W-1:0] res;
    logic [WORD_W-1:0] cnt;
    logic user;
    logic [UB_W-1:0] ub;
  } exec_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] sp;
    logic [WORD_W-1:0] res;
    logic [WORD_W-1:0] cnt;
    logic halt;
    logic user;
    logic [ST_W-1:0] status;
    logic pv;
    logic [WORD_W-1:0] pval;
    logic mw_en;
    logic [WORD_W-1:0] mw_addr;
    logic [WORD_W-1:0] mw_val;
  } exec_out_t;

endpackage

[rtl/mmce_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mmce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mmce_exec.sv]
// Execute unit: computes the architectural update of one instruction from
// its operands and the values already read. Depends on mmce_pkg.
module mmce_exec import mmce_pkg::*; #(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int INST_WORDS = INST_WORDS_DEF
) (
  input  exec_in_t  ex_i,
  output exec_out_t ex_o
);

  function automatic logic ok_addr(input logic [WORD_W-1:0] x, input logic user,
                                   input logic [UB_W-1:0] ub);
    ok_addr = (x < WORD_W'(DATA_WORDS)) && !(user && (x < WORD_W'(ub)));
  endfunction

  logic [WORD_W-1:0] n_pc, n_sp, n_res, n_cnt, sp_dec, pc_inc, push_val;
  logic two, one, post_sp, post_pc;

  always_comb begin
    ex_o = '0;
    n_pc = ex_i.pc;
    n_sp = ex_i.sp;
    n_res = ex_i.res;
    n_cnt = ex_i.cnt;
    ex_o.user = ex_i.user;
    ex_o.status = ST_OK;
    post_sp = 1'b0;
    post_pc = 1'b0;
    two = (ex_i.opc >= 2'd2);
    one = (ex_i.opc >= 2'd1);
    sp_dec = ex_i.sp - 64'd1;
    pc_inc = ex_i.pc + 64'd1;
    push_val = (ex_i.a == 64'(W_SP)) ? sp_dec : ex_i.va;
    if (ex_i.pc >= WORD_W'(INST_WORDS)) begin
      ex_o.halt = 1'b1;
      ex_o.status = ST_PC;
    end else if (ex_i.op >= OP_EMPTY) begin
      n_pc = pc_inc;
      ex_o.status = ST_EMPTY;
    end else begin
      unique case (ex_i.op)
        OP_SET: begin
          if (two) begin
            if (!ok_addr(ex_i.b, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
              ex_o.halt = ex_i.user;
            end else begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = ex_i.b;
              ex_o.mw_val = ex_i.a;
            end
          end
        end
        OP_CPY, OP_ADDI, OP_SUBI, OP_CPYI, OP_CPYI2: begin
          if (two) begin
            if (!ok_addr(ex_i.a, ex_i.user, ex_i.ub) ||
                !ok_addr(ex_i.b, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
              ex_o.halt = ex_i.user;
            end else if (ex_i.op == OP_CPY) begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = ex_i.b;
              ex_o.mw_val = ex_i.va;
            end else if (ex_i.op == OP_ADDI) begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = ex_i.a;
              ex_o.mw_val = ex_i.va + ex_i.vb;
            end else if (ex_i.op == OP_SUBI) begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = ex_i.b;
              ex_o.mw_val = ex_i.vb - ex_i.va;
            end else if (ex_i.op == OP_CPYI) begin
              if (!ok_addr(ex_i.va, ex_i.user, ex_i.ub)) begin
                ex_o.status = ST_VIOL;
                ex_o.halt = ex_i.user;
              end else begin
                ex_o.mw_en = 1'b1;
                ex_o.mw_addr = ex_i.b;
                ex_o.mw_val = ex_i.vc;
              end
            end else begin
              if (!ok_addr(ex_i.va, ex_i.user, ex_i.ub) ||
                  !ok_addr(ex_i.vb, ex_i.user, ex_i.ub)) begin
                ex_o.status = ST_VIOL;
                ex_o.halt = ex_i.user;
              end else begin
                ex_o.mw_en = 1'b1;
                ex_o.mw_addr = ex_i.vb;
                ex_o.mw_val = ex_i.vc;
              end
            end
          end
        end
        OP_ADD: begin
          if (two) begin
            if (!ok_addr(ex_i.a, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
              ex_o.halt = ex_i.user;
            end else begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = ex_i.a;
              ex_o.mw_val = ex_i.va + ex_i.b;
            end
          end
        end
        OP_JIF: begin
          if (two) begin
            if (!ok_addr(ex_i.a, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
              ex_o.halt = ex_i.user;
            end else if ((ex_i.va == '0) || ex_i.va[WORD_W-1]) begin
              n_pc = ex_i.b;
            end
          end
        end
        OP_PUSH: begin
          if (one) begin
            if (!ok_addr(ex_i.a, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
              ex_o.halt = ex_i.user;
            end else begin
              n_sp = sp_dec;
              if (!ok_addr(sp_dec, ex_i.user, ex_i.ub)) begin
                ex_o.status = ST_STACK;
                ex_o.halt = 1'b1;
              end else begin
                ex_o.mw_en = 1'b1;
                ex_o.mw_addr = sp_dec;
                ex_o.mw_val = push_val;
              end
            end
          end
        end
        OP_POP: begin
          if (one) begin
            if (!ok_addr(ex_i.a, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
              ex_o.halt = ex_i.user;
            end else if (!ok_addr(ex_i.sp, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_STACK;
              ex_o.halt = 1'b1;
            end else begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = ex_i.a;
              ex_o.mw_val = ex_i.va;
              post_sp = 1'b1;
            end
          end
        end
        OP_CALL: begin
          if (one) begin
            n_sp = sp_dec;
            if (!ok_addr(sp_dec, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_STACK;
              ex_o.halt = 1'b1;
            end else begin
              ex_o.mw_en = 1'b1;
              ex_o.mw_addr = sp_dec;
              ex_o.mw_val = pc_inc;
              post_pc = 1'b1;
            end
          end
        end
        OP_RET: begin
          if (!ok_addr(ex_i.sp, ex_i.user, ex_i.ub)) begin
            ex_o.status = ST_STACK;
            ex_o.halt = 1'b1;
          end else begin
            n_pc = ex_i.va;
            n_sp = ex_i.sp + 64'd1;
          end
        end
        OP_HLT: begin
          ex_o.halt = 1'b1;
        end
        OP_USER: begin
          if (one) begin
            if (!ok_addr(ex_i.a, ex_i.user, ex_i.ub)) begin
              ex_o.status = ST_VIOL;
            end else begin
              ex_o.user = 1'b1;
              n_pc = ex_i.va;
            end
          end
        end
        OP_PRN: begin
          if (one) begin
            ex_o.user = 1'b0;
            if (ex_i.a >= WORD_W'(DATA_WORDS)) begin
              n_res = '1;
              ex_o.status = ST_VIOL;
            end else begin
              ex_o.pv = 1'b1;
              ex_o.pval = ex_i.va;
              n_res = '0;
            end
          end
        end
        OP_SHLT: begin
          n_res = RES_SHLT;
        end
        default: begin
          n_res = RES_YIELD;
        end
      endcase
      if (ex_o.mw_en && (ex_o.mw_addr[WORD_W-1:2] == '0)) begin
        unique case (ex_o.mw_addr[1:0])
          W_PC: n_pc = ex_o.mw_val;
          W_SP: n_sp = ex_o.mw_val;
          W_RES: n_res = ex_o.mw_val;
          default: n_cnt = ex_o.mw_val;
        endcase
      end
      if (post_sp) begin
        n_sp = n_sp + 64'd1;
      end
      if (post_pc) begin
        n_pc = ex_i.a;
      end
      if (n_pc == ex_i.pc) begin
        n_pc = pc_inc;
      end
      n_cnt = n_cnt + 64'd1;
    end
    ex_o.pc = n_pc;
    ex_o.sp = n_sp;
    ex_o.res = n_res;
    ex_o.cnt = n_cnt;
  end

endmodule

[rtl/memory_to_memory_cpu_execute.sv]
// Top level of the memory-to-memory instruction execute block.
// Depends on mmce_pkg, mmce_ram and mmce_exec.
//
// The input channel (in_valid/in_ready) carries one item per transfer: a
// data word load or one instruction with its opcode and operands. The
// output channel (out_valid/out_ready) returns one result per item.
// A load, or an instruction while halted, gives its result in the cycle
// after the transfer. An executed instruction walks a read sequencer over
// the single data RAM read port (first operand, second operand, indirect
// word, then execute and write back) in states S_RB, S_RC, S_RD and S_EX;
// S_EX registers the result once the output is free. A new item is taken
// only when the sequencer is back at rest and the result register is free
// or being drained; when the receiver stalls, the result holds and the
// next item waits. After reset the data RAM is swept to zero, one word per
// cycle; in_ready stays low during the sweep. The program counter, stack
// pointer, syscall result and count words live in registers and are
// cleared at once. user_base can be written at any time through cfg_wr_en
// and cfg_wr_data; it resets to 1000.
module memory_to_memory_cpu_execute import mmce_pkg::*; #(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int INST_WORDS = INST_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [UB_W-1:0]     cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [OPC_W-1:0]    in_operand_count,
  input  logic [WORD_W-1:0]   in_operand_a,
  input  logic [WORD_W-1:0]   in_operand_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_next_pc,
  output logic                out_halted,
  output logic                out_user_mode,
  output logic [ST_W-1:0]     out_status,
  output logic                out_print_valid,
  output logic [WORD_W-1:0]   out_print_value,
  output logic [WORD_W-1:0]   out_syscall_result
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(DATA_WORDS - 1);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RB = 3'd2;
  localparam logic [2:0] S_RC = 3'd3;
  localparam logic [2:0] S_RD = 3'd4;
  localparam logic [2:0] S_EX = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [UB_W-1:0] ub_r;
  logic [WORD_W-1:0] pc_r, pc_nxt, sp_r, sp_nxt, res_r, res_nxt, cnt_r, cnt_nxt;
  logic user_r, user_nxt, halt_r, halt_nxt;
  logic [OP_W-1:0] op_r;
  logic [OPC_W-1:0] opc_r;
  logic [WORD_W-1:0] a_r, b_r, asel_r, va_r, vb_r, vc_r;
  logic out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] o_pc_r, o_pval_r, o_res_r;
  logic o_halt_r, o_user_r, o_pv_r;
  logic [ST_W-1:0] o_st_r;

  logic out_free, in_xfer, produce;
  logic [WORD_W-1:0] asel, rd_word, rdata, r_pc, r_pval, r_res;
  logic r_halt, r_user, r_pv;
  logic [ST_W-1:0] r_st;
  logic ram_we, ld_ok;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_addr;
  exec_in_t ex_i;
  exec_out_t ex_o;

  mmce_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );

  mmce_exec #(.DATA_WORDS(DATA_WORDS), .INST_WORDS(INST_WORDS)) u_exec (
    .ex_i(ex_i), .ex_o(ex_o)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_xfer = in_valid && in_ready;
  assign asel = ((in_opcode == OP_POP) || (in_opcode == OP_RET)) ? sp_r : in_operand_a;
  assign ld_ok = in_operand_a < WORD_W'(DATA_WORDS);

  // The low words are held in registers; reads of them bypass the RAM.
  always_comb begin
    unique case (state_r)
      S_RB: rd_addr = asel_r;
      S_RC: rd_addr = b_r;
      default: rd_addr = va_r;
    endcase
    if (rd_addr[WORD_W-1:2] == '0) begin
      unique case (rd_addr[1:0])
        W_PC: rd_word = pc_r;
        W_SP: rd_word = sp_r;
        W_RES: rd_word = res_r;
        default: rd_word = cnt_r;
      endcase
    end else begin
      rd_word = rdata;
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE: ram_raddr = asel[AW-1:0];
      S_RB: ram_raddr = b_r[AW-1:0];
      default: ram_raddr = va_r[AW-1:0];
    endcase
  end

  always_comb begin
    ex_i.op = op_r;
    ex_i.opc = opc_r;
    ex_i.a = a_r;
    ex_i.b = b_r;
    ex_i.va = va_r;
    ex_i.vb = vb_r;
    ex_i.vc = vc_r;
    ex_i.pc = pc_r;
    ex_i.sp = sp_r;
    ex_i.res = res_r;
    ex_i.cnt = cnt_r;
    ex_i.user = user_r;
    ex_i.ub = ub_r;
  end

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt = pc_r;
    sp_nxt = sp_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    user_nxt = user_r;
    halt_nxt = halt_r;
    ram_we = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    produce = 1'b0;
    r_st = ST_OK;
    r_pv = 1'b0;
    r_pval = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_action) begin
            produce = 1'b1;
            if (!ld_ok) begin
              r_st = ST_LOAD;
            end else if (in_operand_a[WORD_W-1:2] == '0) begin
              unique case (in_operand_a[1:0])
                W_PC: pc_nxt = in_operand_b;
                W_SP: sp_nxt = in_operand_b;
                W_RES: res_nxt = in_operand_b;
                default: cnt_nxt = in_operand_b;
              endcase
            end else begin
              ram_we = 1'b1;
              ram_waddr = in_operand_a[AW-1:0];
              ram_wdata = in_operand_b;
            end
          end else if (halt_r) begin
            produce = 1'b1;
          end else begin
            state_nxt = S_RB;
          end
        end
      end
      S_RB: state_nxt = S_RC;
      S_RC: state_nxt = S_RD;
      S_RD: state_nxt = S_EX;
      S_EX: begin
        if (out_free) begin
          produce = 1'b1;
          state_nxt = S_IDLE;
          pc_nxt = ex_o.pc;
          sp_nxt = ex_o.sp;
          res_nxt = ex_o.res;
          cnt_nxt = ex_o.cnt;
          user_nxt = ex_o.user;
          halt_nxt = halt_r || ex_o.halt;
          r_st = ex_o.status;
          r_pv = ex_o.pv;
          r_pval = ex_o.pval;
          if (ex_o.mw_en && (ex_o.mw_addr[WORD_W-1:2] != '0)) begin
            ram_we = 1'b1;
            ram_waddr = ex_o.mw_addr[AW-1:0];
            ram_wdata = ex_o.mw_val;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    r_pc = pc_nxt;
    r_res = res_nxt;
    r_halt = halt_nxt;
    r_user = user_nxt;
    out_valid_nxt = produce || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      ub_r <= USER_BASE_RST;
      pc_r <= '0;
      sp_r <= '0;
      res_r <= '0;
      cnt_r <= '0;
      user_r <= 1'b0;
      halt_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        ub_r <= cfg_wr_data;
      end
      pc_r <= pc_nxt;
      sp_r <= sp_nxt;
      res_r <= res_nxt;
      cnt_r <= cnt_nxt;
      user_r <= user_nxt;
      halt_r <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_opcode;
      opc_r <= in_operand_count;
      a_r <= in_operand_a;
      b_r <= in_operand_b;
      asel_r <= asel;
    end
    if (state_r == S_RB) begin
      va_r <= rd_word;
    end
    if (state_r == S_RC) begin
      vb_r <= rd_word;
    end
    if (state_r == S_RD) begin
      vc_r <= rd_word;
    end
    if (produce) begin
      o_pc_r <= r_pc;
      o_halt_r <= r_halt;
      o_user_r <= r_user;
      o_st_r <= r_st;
      o_pv_r <= r_pv;
      o_pval_r <= r_pval;
      o_res_r <= r_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_next_pc = o_pc_r;
  assign out_halted = o_halt_r;
  assign out_user_mode = o_user_r;
  assign out_status = o_st_r;
  assign out_print_valid = o_pv_r;
  assign out_print_value = o_pval_r;
  assign out_syscall_result = o_res_r;

`ifndef SYNTHESIS
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("Input transfer possible during the memory sweep.");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("Halt flag cleared without reset.");
  a_exec_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_action && !halt_r) |=> (state_r == S_RB))
    else $error("Instruction transfer did not start the read sequence.");
  a_user_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(user_r) |-> ($past(state_r) == S_EX))
    else $error("User mode entered outside instruction completion.");
`endif

endmodule

[verif/mmce_checker.sv]
// Result checker for the memory-to-memory instruction execute block.
// Keeps its own copy of data memory, mode and halt state, predicts each result
// and compares it with the block's output. Depends on mmce_pkg.
module mmce_checker import mmce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [UB_W-1:0]   cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_action,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [OPC_W-1:0]  in_operand_count,
  input  logic [WORD_W-1:0] in_operand_a,
  input  logic [WORD_W-1:0] in_operand_b,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [WORD_W-1:0] out_next_pc,
  input  logic              out_halted,
  input  logic              out_user_mode,
  input  logic [ST_W-1:0]   out_status,
  input  logic              out_print_valid,
  input  logic [WORD_W-1:0] out_print_value,
  input  logic [WORD_W-1:0] out_syscall_result,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic              halted;
    logic              user;
    logic [ST_W-1:0]   status;
    logic              pv;
    logic [WORD_W-1:0] pval;
    logic [WORD_W-1:0] res;
  } step_result_t;

  logic [WORD_W-1:0] mem_copy [DATA_WORDS_DEF];
  logic              in_user;
  logic              is_halted;
  logic [UB_W-1:0]   base_copy;
  logic [ST_W-1:0]   cur_status;
  step_result_t      awaited_q[$];

  function automatic bit addr_ok(logic [WORD_W-1:0] ad);
    return (ad < DATA_WORDS_DEF) && !(in_user && ad < base_copy);
  endfunction

  function automatic void access_fault();
    cur_status = ST_VIOL;
    if (in_user) is_halted = 1'b1;
  endfunction

  function automatic void stack_fault();
    cur_status = ST_STACK;
    is_halted = 1'b1;
  endfunction

  function automatic step_result_t execute_step(logic act, logic [OP_W-1:0] op,
                                                logic [OPC_W-1:0] cnt,
                                                logic [WORD_W-1:0] a,
                                                logic [WORD_W-1:0] b);
    step_result_t r;
    logic [WORD_W-1:0] pc, s, d, v;
    bit two, one;
    r = '0;
    cur_status = ST_OK;
    two = cnt >= 2;
    one = cnt >= 1;
    if (act) begin
      if (a < DATA_WORDS_DEF) mem_copy[a[10:0]] = b;
      else cur_status = ST_LOAD;
    end else if (!is_halted) begin
      pc = mem_copy[W_PC];
      if (pc >= INST_WORDS_DEF) begin
        is_halted = 1'b1;
        cur_status = ST_PC;
      end else if (op > OP_YIELD) begin
        mem_copy[W_PC] = pc + 1;
        cur_status = ST_EMPTY;
      end else begin
        case (op)
          OP_SET: if (two) begin
            if (!addr_ok(b)) access_fault();
            else mem_copy[b[10:0]] = a;
          end
          OP_ADD: if (two) begin
            if (!addr_ok(a)) access_fault();
            else mem_copy[a[10:0]] = mem_copy[a[10:0]] + b;
          end
          OP_CPY, OP_ADDI, OP_SUBI: if (two) begin
            if (!addr_ok(a) || !addr_ok(b)) access_fault();
            else if (op == OP_CPY) mem_copy[b[10:0]] = mem_copy[a[10:0]];
            else if (op == OP_ADDI)
              mem_copy[a[10:0]] = mem_copy[a[10:0]] + mem_copy[b[10:0]];
            else mem_copy[b[10:0]] = mem_copy[b[10:0]] - mem_copy[a[10:0]];
          end
          OP_CPYI: if (two) begin
            if (!addr_ok(a) || !addr_ok(b)) access_fault();
            else begin
              s = mem_copy[a[10:0]];
              if (!addr_ok(s)) access_fault();
              else mem_copy[b[10:0]] = mem_copy[s[10:0]];
            end
          end
          OP_CPYI2: if (two) begin
            if (!addr_ok(a) || !addr_ok(b)) access_fault();
            else begin
              s = mem_copy[a[10:0]];
              d = mem_copy[b[10:0]];
              if (!addr_ok(s) || !addr_ok(d)) access_fault();
              else mem_copy[d[10:0]] = mem_copy[s[10:0]];
            end
          end
          OP_JIF: if (two) begin
            if (!addr_ok(a)) access_fault();
            else begin
              v = mem_copy[a[10:0]];
              if (v == 0 || v[63]) mem_copy[W_PC] = b;
            end
          end
          OP_PUSH: if (one) begin
            if (!addr_ok(a)) access_fault();
            else begin
              mem_copy[W_SP] = mem_copy[W_SP] - 1;
              s = mem_copy[W_SP];
              if (!addr_ok(s)) stack_fault();
              else mem_copy[s[10:0]] = mem_copy[a[10:0]];
            end
          end
          OP_POP: if (one) begin
            if (!addr_ok(a)) access_fault();
            else begin
              s = mem_copy[W_SP];
              if (!addr_ok(s)) stack_fault();
              else begin
                mem_copy[a[10:0]] = mem_copy[s[10:0]];
                mem_copy[W_SP] = mem_copy[W_SP] + 1;
              end
            end
          end
          OP_CALL: if (one) begin
            v = mem_copy[W_PC] + 1;
            mem_copy[W_SP] = mem_copy[W_SP] - 1;
            s = mem_copy[W_SP];
            if (!addr_ok(s)) stack_fault();
            else begin
              mem_copy[s[10:0]] = v;
              mem_copy[W_PC] = a;
            end
          end
          OP_RET: begin
            s = mem_copy[W_SP];
            if (!addr_ok(s)) stack_fault();
            else begin
              mem_copy[W_PC] = mem_copy[s[10:0]];
              mem_copy[W_SP] = mem_copy[W_SP] + 1;
            end
          end
          OP_HLT: is_halted = 1'b1;
          OP_USER: if (one) begin
            if (!addr_ok(a)) cur_status = ST_VIOL;
            else begin
              in_user = 1'b1;
              mem_copy[W_PC] = mem_copy[a[10:0]];
            end
          end
          OP_PRN: if (one) begin
            in_user = 1'b0;
            if (a >= DATA_WORDS_DEF) begin
              mem_copy[W_RES] = '1;
              cur_status = ST_VIOL;
            end else begin
              r.pv = 1'b1;
              r.pval = mem_copy[a[10:0]];
              mem_copy[W_RES] = '0;
            end
          end
          OP_SHLT: mem_copy[W_RES] = RES_SHLT;
          default: mem_copy[W_RES] = RES_YIELD;
        endcase
        if (mem_copy[W_PC] == pc) mem_copy[W_PC] = pc + 1;
        mem_copy[W_CNT] = mem_copy[W_CNT] + 1;
      end
    end
    r.pc = mem_copy[W_PC];
    r.halted = is_halted;
    r.user = in_user;
    r.status = cur_status;
    r.res = mem_copy[W_RES];
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DATA_WORDS_DEF; i++) mem_copy[i] = '0;
      in_user = 1'b0;
      is_halted = 1'b0;
      base_copy = USER_BASE_RST;
      awaited_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) base_copy = cfg_wr_data;
      if (in_valid && in_ready)
        awaited_q.push_back(execute_step(in_action, in_opcode, in_operand_count,
                                         in_operand_a, in_operand_b));
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result transfer, none pending");
        end else begin
          want = awaited_q.pop_front();
          if (out_next_pc !== want.pc || out_halted !== want.halted ||
              out_user_mode !== want.user || out_status !== want.status ||
              out_print_valid !== want.pv || out_print_value !== want.pval ||
              out_syscall_result !== want.res) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch: pc %h/%h halt %b/%b user %b/%b status %0d/%0d",
                       want.pc, out_next_pc, want.halted, out_halted,
                       want.user, out_user_mode, want.status, out_status);
              $display("  print %b %h / %b %h  syscall %h/%h", want.pv, want.pval,
                       out_print_valid, out_print_value, want.res,
                       out_syscall_result);
            end
          end
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the memory-to-memory instruction execute block.
// Drives directed and random instruction streams and reports the verdict.
// Depends on mmce_pkg, memory_to_memory_cpu_execute and mmce_checker.
module tb_top;
  import mmce_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [UB_W-1:0]   cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_action;
  logic [OP_W-1:0]   in_opcode;
  logic [OPC_W-1:0]  in_operand_count;
  logic [WORD_W-1:0] in_operand_a;
  logic [WORD_W-1:0] in_operand_b;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_next_pc;
  logic              out_halted;
  logic              out_user_mode;
  logic [ST_W-1:0]   out_status;
  logic              out_print_valid;
  logic [WORD_W-1:0] out_print_value;
  logic [WORD_W-1:0] out_syscall_result;
  int                fail_count;
  int                pending;

  int tx_idle;
  int rx_idle;
  int hold_req;
  int hold_ack;
  int items_sent;
  int cur_base;

  memory_to_memory_cpu_execute uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_opcode(in_opcode), .in_operand_count(in_operand_count),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_next_pc(out_next_pc),
    .out_halted(out_halted), .out_user_mode(out_user_mode),
    .out_status(out_status), .out_print_valid(out_print_valid),
    .out_print_value(out_print_value), .out_syscall_result(out_syscall_result)
  );

  mmce_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_opcode(in_opcode), .in_operand_count(in_operand_count),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_next_pc(out_next_pc),
    .out_halted(out_halted), .out_user_mode(out_user_mode),
    .out_status(out_status), .out_print_valid(out_print_valid),
    .out_print_value(out_print_value), .out_syscall_result(out_syscall_result),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver holds off for a long stretch whenever the stimulus asks.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_ack = hold_req;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [WORD_W-1:0] kernel_addr();
    int r;
    r = $urandom_range(99);
    if (r < 5) return rand_word();
    if (r < 10) return $urandom_range(0, 3);
    return $urandom_range(4, 2047);
  endfunction

  function automatic logic [WORD_W-1:0] data_value();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(4, 2047);
    if (r < 45) return '0;
    if (r < 60) return rand_word() | {1'b1, 63'd0};
    return rand_word();
  endfunction

  task automatic send_item(logic act, logic [OP_W-1:0] op, logic [OPC_W-1:0] cnt,
                           logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_opcode <= op;
    in_operand_count <= cnt;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_word(logic [WORD_W-1:0] a, logic [WORD_W-1:0] v);
    send_item(1'b1, OP_W'($urandom_range(0, 31)), OPC_W'($urandom_range(0, 3)), a, v);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_base(logic [UB_W-1:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_base = value;
  endtask

  // One kernel instruction, with PC and SP reloaded first so that no halt occurs.
  task automatic kernel_instr();
    logic [OP_W-1:0] op;
    logic [OPC_W-1:0] cnt;
    logic [WORD_W-1:0] a, b;
    load_word(W_PC, $urandom_range(0, 1000));
    load_word(W_SP, $urandom_range(1, 2047));
    op = $urandom_range(0, 16);
    if ($urandom_range(99) < 8) op = $urandom_range(17, 31);
    if (op == OP_HLT) op = OP_JIF;
    cnt = ($urandom_range(99) < 85) ? OPC_W'(2) : OPC_W'($urandom_range(0, 3));
    a = kernel_addr();
    b = kernel_addr();
    if (op == OP_SET) a = data_value();
    if (op == OP_ADD) b = rand_word();
    if (op == OP_JIF && $urandom_range(1)) b = $urandom_range(0, 1023);
    if (op == OP_CALL && $urandom_range(1)) a = $urandom_range(0, 1023);
    if (op == OP_USER) a = rand_word() | {1'b1, 63'd0};
    if (a < 2048 && $urandom_range(1)) load_word(a, data_value());
    if (b < 2048 && $urandom_range(1)) load_word(b, data_value());
    if ($urandom_range(99) < 3) load_word(rand_word() | {1'b1, 63'd0}, rand_word());
    send_item(1'b0, op, cnt, a, b);
  endtask

  // Enter user mode, run a few well-formed instructions, and return by print.
  task automatic user_sequence();
    int lo, t, sp, n;
    logic [OP_W-1:0] op;
    logic [WORD_W-1:0] a, b;
    lo = (cur_base < 4) ? 4 : cur_base;
    t = $urandom_range(lo, 2047);
    load_word(W_PC, $urandom_range(0, 900));
    load_word(t, $urandom_range(0, 900));
    send_item(1'b0, OP_USER, OPC_W'($urandom_range(1, 3)), t, rand_word());
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 13))
        0: op = OP_SET;    1: op = OP_CPY;   2: op = OP_CPYI;  3: op = OP_CPYI2;
        4: op = OP_ADD;    5: op = OP_ADDI;  6: op = OP_SUBI;  7: op = OP_JIF;
        8: op = OP_PUSH;   9: op = OP_POP;   10: op = OP_CALL; 11: op = OP_RET;
        12: op = OP_SHLT;  default: op = OP_YIELD;
      endcase
      if (lo >= 2046 && (op == OP_PUSH || op == OP_POP || op == OP_CALL || op == OP_RET))
        op = OP_YIELD;
      a = $urandom_range(lo, 2047);
      b = $urandom_range(lo, 2047);
      load_word(a, (op == OP_JIF) ? data_value() : $urandom_range(lo, 2047));
      load_word(b, $urandom_range(lo, 2047));
      if (op == OP_SET) a = rand_word();
      if (op == OP_ADD) b = rand_word();
      if (op == OP_JIF) b = $urandom_range(0, 900);
      if (op == OP_CALL) a = $urandom_range(0, 900);
      if (op == OP_PUSH || op == OP_POP || op == OP_CALL || op == OP_RET) begin
        sp = $urandom_range(lo + 1, 2047);
        load_word(W_SP, sp);
        if (op == OP_RET) load_word(sp, $urandom_range(0, 900));
      end
      send_item(1'b0, op, OPC_W'(2), a, b);
    end
    a = ($urandom_range(99) < 10) ? rand_word() | {1'b1, 63'd0}
                                  : {53'd0, 11'($urandom_range(0, 2047))};
    send_item(1'b0, OP_PRN, OPC_W'($urandom_range(1, 3)), a, rand_word());
  endtask

  task automatic directed_part();
    load_word(2047, 64'h7fff_ffff_ffff_ffff);
    load_word(5, 64'h8000_0000_0000_0000);
    load_word(64'hffff_ffff_ffff_ffff, 64'h1234);
    load_word(W_SP, 100);
    load_word(12, 2047);
    load_word(14, 20);
    send_item(1'b0, OP_SET, 2, 64'hffff_ffff_ffff_ffff, 10);
    send_item(1'b0, OP_SET, 0, 7, 11);
    send_item(1'b0, OP_CPY, 2, 5, 11);
    send_item(1'b0, OP_CPYI, 2, 12, 13);
    send_item(1'b0, OP_CPYI2, 2, 12, 14);
    send_item(1'b0, OP_ADD, 2, 10, 64'h7fff_ffff_ffff_ffff);
    send_item(1'b0, OP_ADDI, 2, 10, 2047);
    send_item(1'b0, OP_SUBI, 2, 5, 10);
    send_item(1'b0, OP_JIF, 2, 5, 50);
    send_item(1'b0, OP_JIF, 2, 5, 51);
    send_item(1'b0, OP_PUSH, 1, 5, 0);
    send_item(1'b0, OP_POP, 1, 15, 0);
    send_item(1'b0, OP_CALL, 1, 60, 0);
    send_item(1'b0, OP_RET, 0, 0, 0);
    send_item(1'b0, OP_USER, 1, 64'h8000_0000_0000_0000, 0);
    send_item(1'b0, OP_PRN, 1, 2047, 0);
    send_item(1'b0, OP_PRN, 1, 2048, 0);
    send_item(1'b0, OP_SHLT, 0, 0, 0);
    send_item(1'b0, OP_YIELD, 0, 0, 0);
    send_item(1'b0, OP_EMPTY, 2, 0, 0);
    send_item(1'b0, 5'd31, 3, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
  endtask

  task automatic halting_part();
    logic [WORD_W-1:0] a;
    load_word(W_PC, 10);
    case ($urandom_range(0, 3))
      0: send_item(1'b0, OP_HLT, 0, 0, 0);
      1: begin
        load_word(2047, 5);
        send_item(1'b0, OP_USER, 1, 2047, 0);
        send_item(1'b0, OP_SET, 2, 1, 64'hffff_0000_0000_0000);
      end
      2: begin
        load_word(W_SP, 0);
        send_item(1'b0, OP_PUSH, 1, 4, 0);
      end
      default: begin
        load_word(W_PC, 5000);
        send_item(1'b0, OP_YIELD, 0, 0, 0);
      end
    endcase
    repeat (12) begin
      a = kernel_addr();
      if ($urandom_range(1)) load_word(a, rand_word());
      else send_item(1'b0, OP_W'($urandom_range(0, 31)), OPC_W'($urandom_range(0, 3)),
                     a, kernel_addr());
    end
  endtask

  initial begin
    int phase_start;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_opcode = '0;
    in_operand_count = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 0;
    hold_ack = 0;
    items_sent = 0;
    cur_base = 1000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_base(1000);
    directed_part();
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 31 : (ph == 1) ? 55 : 0;
      rx_idle = (ph == 0) ? 55 : (ph == 1) ? 31 : 0;
      write_base((ph == 0) ? UB_W'($urandom_range(1, 2046)) : (ph == 1) ? UB_W'(0)
                                                               : UB_W'(2047));
      phase_start = items_sent;
      while (items_sent - phase_start < 570) begin
        if ($urandom_range(99) < 70) kernel_instr();
        else user_sequence();
        if (ph == 0 && hold_req == 0 && items_sent - phase_start > 150) hold_req = 1;
        if (ph == 1 && items_sent - phase_start > 300 && items_sent - phase_start < 310) begin
          in_valid <= 1'b0;
          @(negedge clk);
          wait_drained();
        end
      end
    end
    halting_part();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
